// ===== rtl/cascaded_attitude_rate_pid_defines.svh =====
// assertion macros used by the controller sequencer (carpid_ctrl)
`ifndef CASCADED_ATTITUDE_RATE_PID_DEFINES_SVH
`define CASCADED_ATTITUDE_RATE_PID_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CARPID_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CARPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/carpid_pkg.sv =====
package carpid_pkg;

  typedef struct packed {
    logic signed [15:0] cmd_roll;
    logic signed [15:0] cmd_pitch;
    logic signed [15:0] cmd_heading;
    logic signed [15:0] sin_roll;
    logic signed [15:0] sin_pitch;
    logic        [15:0] heading;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } carpid_in_t;

  typedef struct packed {
    logic signed [15:0] roll_out;
    logic signed [15:0] pitch_out;
    logic signed [15:0] yaw_out;
  } carpid_out_t;

  // register indexes
  localparam logic [2:0] REG_TILT_KI   = 3'd0;
  localparam logic [2:0] REG_RATE_KI   = 3'd1;
  localparam logic [2:0] REG_YAW_KI    = 3'd2;
  localparam logic [2:0] REG_ROLL_GAIN = 3'd3;
  localparam logic [2:0] REG_PTCH_GAIN = 3'd4;
  localparam logic [2:0] REG_YAW_GAIN  = 3'd5;
  localparam logic [2:0] REG_YAW_DIR   = 3'd6;

  // axis codes
  localparam logic [1:0] AX_ROLL  = 2'd0;
  localparam logic [1:0] AX_PITCH = 2'd1;
  localparam logic [1:0] AX_YAW   = 2'd2;

  // multiplier operand selects
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_TILT = 3'd1;
  localparam logic [2:0] MUL_KI   = 3'd2;
  localparam logic [2:0] MUL_KP   = 3'd3;
  localparam logic [2:0] MUL_KD   = 3'd4;
  localparam logic [2:0] MUL_DIR  = 3'd5;

  // uses of the registered product
  localparam logic [2:0] UPD_NONE = 3'd0;
  localparam logic [2:0] UPD_TILT = 3'd1;
  localparam logic [2:0] UPD_ERR  = 3'd2;
  localparam logic [2:0] UPD_RINT = 3'd3;
  localparam logic [2:0] UPD_ACCP = 3'd4;
  localparam logic [2:0] UPD_ACCD = 3'd5;
  localparam logic [2:0] UPD_YAW  = 3'd6;

  localparam logic signed [26:0] INT_LIMIT     = 27'sd32768000;
  localparam logic signed [26:0] INT_LIMIT_NEG = -27'sd32768000;

  typedef struct packed {
    logic       load;
    logic [2:0] mul_op;
    logic [1:0] mul_ax;
    logic [2:0] upd_op;
    logic [1:0] upd_ax;
    logic       out_load;
  } carpid_cmd_t;

endpackage

// ===== rtl/cascaded_attitude_rate_pid.sv =====
// Cascaded attitude and rate controller, one control tick per input transfer: an outer PI
// loop turns roll and pitch tilt errors into rate setpoints, an inner PID loop per axis
// acts on rate error and gives roll, pitch and yaw drives (yaw times the direction sign).
// One tick is worked at a time by a single 17x16 signed multiplier stepped through sixteen
// operations by the controller; after the last step the result is loaded into the output
// register once that is free, raising out_valid, and only then is the next input taken. A
// finished result waits in the output register while the next tick is
// computed. Configuration writes are always ready and take effect at once; write them only
// while no tick is in progress. Integral and derivative state is cleared by reset.
module cascaded_attitude_rate_pid import carpid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input transfer
  input  logic        in_valid,
  output logic        in_stall,
  input  carpid_in_t  in_data,
  // result transfer
  output logic        out_valid,
  input  logic        out_stall,
  output carpid_out_t out_data,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  carpid_cmd_t cmd;

  // registers are plain flops, never busy
  assign cfg_ready = 1'b1;

  // sequencer: idle, sixteen multiply and update steps, output load
  carpid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // gains, loop state, shared multiplier and output register
  carpid_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/carpid_ctrl.sv =====
`include "cascaded_attitude_rate_pid_defines.svh"

module carpid_ctrl import carpid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output carpid_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [4:0] STEP_FIRST = 5'd1;
  localparam logic [4:0] STEP_LAST  = 5'd16;

  logic [1:0] state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
          step_nxt  = STEP_FIRST;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 5'd1;
        if (step_r == STEP_LAST) state_nxt = ST_FIN;
        unique case (step_r)
          5'd1: begin
            cmd.mul_op = MUL_TILT; cmd.mul_ax = AX_ROLL;
          end
          5'd2: begin
            cmd.mul_op = MUL_TILT; cmd.mul_ax = AX_PITCH;
            cmd.upd_op = UPD_TILT; cmd.upd_ax = AX_ROLL;
          end
          5'd3: begin
            cmd.upd_op = UPD_TILT; cmd.upd_ax = AX_PITCH;
          end
          5'd4: begin
            cmd.upd_op = UPD_ERR;
          end
          5'd5: begin
            cmd.mul_op = MUL_KI; cmd.mul_ax = AX_ROLL;
          end
          5'd6: begin
            cmd.mul_op = MUL_KP;   cmd.mul_ax = AX_ROLL;
            cmd.upd_op = UPD_RINT; cmd.upd_ax = AX_ROLL;
          end
          5'd7: begin
            cmd.mul_op = MUL_KD;   cmd.mul_ax = AX_ROLL;
            cmd.upd_op = UPD_ACCP; cmd.upd_ax = AX_ROLL;
          end
          5'd8: begin
            cmd.mul_op = MUL_KI;   cmd.mul_ax = AX_PITCH;
            cmd.upd_op = UPD_ACCD; cmd.upd_ax = AX_ROLL;
          end
          5'd9: begin
            cmd.mul_op = MUL_KP;   cmd.mul_ax = AX_PITCH;
            cmd.upd_op = UPD_RINT; cmd.upd_ax = AX_PITCH;
          end
          5'd10: begin
            cmd.mul_op = MUL_KD;   cmd.mul_ax = AX_PITCH;
            cmd.upd_op = UPD_ACCP; cmd.upd_ax = AX_PITCH;
          end
          5'd11: begin
            cmd.mul_op = MUL_KI;   cmd.mul_ax = AX_YAW;
            cmd.upd_op = UPD_ACCD; cmd.upd_ax = AX_PITCH;
          end
          5'd12: begin
            cmd.mul_op = MUL_KP;   cmd.mul_ax = AX_YAW;
            cmd.upd_op = UPD_RINT; cmd.upd_ax = AX_YAW;
          end
          5'd13: begin
            cmd.mul_op = MUL_KD;   cmd.mul_ax = AX_YAW;
            cmd.upd_op = UPD_ACCP; cmd.upd_ax = AX_YAW;
          end
          5'd14: begin
            cmd.upd_op = UPD_ACCD; cmd.upd_ax = AX_YAW;
          end
          5'd15: begin
            cmd.mul_op = MUL_DIR;
          end
          5'd16: begin
            cmd.upd_op = UPD_YAW;
          end
          default: ;
        endcase
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CARPID_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == ST_RUN && step_r == STEP_FIRST, "accepted item did not start the sequence")
  `CARPID_ASSERT_NEXT(a_run_finishes, state_r == ST_RUN && step_r == STEP_LAST, state_r == ST_FIN, "sequence did not reach finish")
  `CARPID_ASSERT_NEXT(a_no_overwrite, state_r == ST_FIN && out_valid_r && out_stall, state_r == ST_FIN && out_valid_r, "waiting result overwritten")

endmodule

// ===== rtl/carpid_dp.sv =====
module carpid_dp import carpid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  carpid_in_t  in_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  carpid_cmd_t cmd,
  output carpid_out_t out_data
);

  // clamped accumulate of a product shifted right by 8
  function automatic logic [25:0] integ(input logic [25:0] acc, input logic [32:0] p);
    logic signed [26:0] sum;
    sum = {acc[25], acc} + {{2{p[32]}}, p[32:8]};
    if (sum > INT_LIMIT)          integ = INT_LIMIT[25:0];
    else if (sum < INT_LIMIT_NEG) integ = INT_LIMIT_NEG[25:0];
    else                          integ = sum[25:0];
  endfunction

  // integral shifted right by 16, sign extended to 16 bits
  function automatic logic [15:0] int_hi(input logic [25:0] v);
    int_hi = {{6{v[25]}}, v[25:16]};
  endfunction

  logic [15:0] ti_gain_r, ti_gain_nxt;
  logic [15:0] ri_gain_r, ri_gain_nxt;
  logic [15:0] yi_gain_r, yi_gain_nxt;
  logic [31:0] roll_g_r, roll_g_nxt;
  logic [31:0] pitch_g_r, pitch_g_nxt;
  logic [31:0] yaw_g_r, yaw_g_nxt;
  logic [1:0]  yaw_dir_r, yaw_dir_nxt;

  logic [15:0] ang_roll_r, ang_pitch_r, ang_yaw_r;
  logic [15:0] gyro_x_r, gyro_y_r, gyro_z_r;

  logic [25:0] tint_r [2];
  logic [25:0] tint_nxt [2];
  logic [25:0] rint_r [3];
  logic [25:0] rint_nxt [3];
  logic [15:0] prev_r [3];
  logic [15:0] prev_nxt [3];
  logic [15:0] err_r [3];
  logic [15:0] err_nxt [3];
  logic [15:0] dif_r [3];
  logic [15:0] dif_nxt [3];
  logic [15:0] ctl_r [3];
  logic [15:0] ctl_nxt [3];

  logic signed [16:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [32:0] prod_r, prod_nxt;
  logic [31:0]        rate_gains;
  logic [15:0]        set_roll, set_pitch;
  carpid_out_t        out_r, out_nxt;

  // configuration registers
  always_comb begin
    ti_gain_nxt = ti_gain_r;
    ri_gain_nxt = ri_gain_r;
    yi_gain_nxt = yi_gain_r;
    roll_g_nxt  = roll_g_r;
    pitch_g_nxt = pitch_g_r;
    yaw_g_nxt   = yaw_g_r;
    yaw_dir_nxt = yaw_dir_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_TILT_KI:   ti_gain_nxt = cfg_data[15:0];
        REG_RATE_KI:   ri_gain_nxt = cfg_data[15:0];
        REG_YAW_KI:    yi_gain_nxt = cfg_data[15:0];
        REG_ROLL_GAIN: roll_g_nxt  = cfg_data;
        REG_PTCH_GAIN: pitch_g_nxt = cfg_data;
        REG_YAW_GAIN:  yaw_g_nxt   = cfg_data;
        REG_YAW_DIR:   yaw_dir_nxt = cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  always_comb begin
    case (cmd.mul_ax)
      AX_ROLL:  rate_gains = roll_g_r;
      AX_PITCH: rate_gains = pitch_g_r;
      default:  rate_gains = yaw_g_r;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_TILT: begin
        mul_a = {1'b0, ti_gain_r};
        mul_b = (cmd.mul_ax == AX_ROLL) ? ang_roll_r : ang_pitch_r;
      end
      MUL_KI: begin
        mul_a = {1'b0, (cmd.mul_ax == AX_YAW) ? yi_gain_r : ri_gain_r};
        mul_b = err_r[cmd.mul_ax];
      end
      MUL_KP: begin
        mul_a = {1'b0, rate_gains[31:16]};
        mul_b = err_r[cmd.mul_ax];
      end
      MUL_KD: begin
        mul_a = {1'b0, rate_gains[15:0]};
        mul_b = dif_r[cmd.mul_ax];
      end
      MUL_DIR: begin
        mul_a = {{15{yaw_dir_r[1]}}, yaw_dir_r};
        mul_b = ctl_r[AX_YAW];
      end
      default: ;
    endcase
  end

  assign prod_nxt = 33'(mul_a) * 33'(mul_b);

  // rate setpoints from tilt error plus tilt integral
  assign set_roll  = ang_roll_r + int_hi(tint_r[0]);
  assign set_pitch = ang_pitch_r + int_hi(tint_r[1]);

  always_comb begin
    tint_nxt = tint_r;
    rint_nxt = rint_r;
    prev_nxt = prev_r;
    err_nxt  = err_r;
    dif_nxt  = dif_r;
    ctl_nxt  = ctl_r;
    case (cmd.upd_op)
      UPD_TILT: tint_nxt[cmd.upd_ax[0]] = integ(tint_r[cmd.upd_ax[0]], prod_r);
      UPD_ERR: begin
        err_nxt[0] = {{2{set_roll[15]}}, set_roll[15:2]} - gyro_y_r;
        err_nxt[1] = {{2{set_pitch[15]}}, set_pitch[15:2]} - gyro_x_r;
        err_nxt[2] = ang_yaw_r - gyro_z_r;
        for (int i = 0; i < 3; i++) begin
          dif_nxt[i]  = err_nxt[i] - prev_r[i];
          prev_nxt[i] = err_nxt[i];
        end
      end
      UPD_RINT: rint_nxt[cmd.upd_ax] = integ(rint_r[cmd.upd_ax], prod_r);
      UPD_ACCP: ctl_nxt[cmd.upd_ax] = prod_r[31:16] + int_hi(rint_r[cmd.upd_ax]);
      UPD_ACCD: ctl_nxt[cmd.upd_ax] = ctl_r[cmd.upd_ax] + prod_r[31:16];
      UPD_YAW:  ctl_nxt[AX_YAW] = prod_r[15:0];
      default: ;
    endcase
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.out_load) out_nxt = {ctl_r[AX_ROLL], ctl_r[AX_PITCH], ctl_r[AX_YAW]};
  end

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ti_gain_r <= '0;
      ri_gain_r <= '0;
      yi_gain_r <= '0;
      roll_g_r  <= '0;
      pitch_g_r <= '0;
      yaw_g_r   <= '0;
      yaw_dir_r <= 2'b01;
      tint_r    <= '{default: '0};
      rint_r    <= '{default: '0};
      prev_r    <= '{default: '0};
    end else begin
      ti_gain_r <= ti_gain_nxt;
      ri_gain_r <= ri_gain_nxt;
      yi_gain_r <= yi_gain_nxt;
      roll_g_r  <= roll_g_nxt;
      pitch_g_r <= pitch_g_nxt;
      yaw_g_r   <= yaw_g_nxt;
      yaw_dir_r <= yaw_dir_nxt;
      tint_r    <= tint_nxt;
      rint_r    <= rint_nxt;
      prev_r    <= prev_nxt;
    end
  end

  // payload registers, plus the product and working registers that are not reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ang_roll_r  <= in_data.cmd_roll + in_data.sin_roll;
      ang_pitch_r <= in_data.cmd_pitch - in_data.sin_pitch;
      ang_yaw_r   <= in_data.heading - in_data.cmd_heading;
      gyro_x_r    <= in_data.gyro_x;
      gyro_y_r    <= in_data.gyro_y;
      gyro_z_r    <= in_data.gyro_z;
    end
    prod_r <= prod_nxt;
    err_r  <= err_nxt;
    dif_r  <= dif_nxt;
    ctl_r  <= ctl_nxt;
    out_r  <= out_nxt;
  end

endmodule
